### src/albs_pkg.sv
// Shared types and constants for the addressable LED bit serializer.
// Holds the input, result and configuration structs, function codes and register indexes.
// No dependencies.
package albs_pkg;

    localparam int PINS_W = 32;
    localparam int WORD_W = 32;
    localparam int DUR_W  = 16;
    localparam int TICK_W = 24;
    localparam int POS_W  = 5;
    localparam int IDX_W  = 3;

    // Function codes carried in the input item.
    localparam logic [1:0] FUNC_IDLE = 2'd0;
    localparam logic [1:0] FUNC_WORD = 2'd1;
    localparam logic [1:0] FUNC_END  = 2'd2;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_PIN_MASK    = 3'd0;
    localparam logic [IDX_W-1:0] CFG_T0_HIGH     = 3'd1;
    localparam logic [IDX_W-1:0] CFG_T0_LOW      = 3'd2;
    localparam logic [IDX_W-1:0] CFG_T1_HIGH     = 3'd3;
    localparam logic [IDX_W-1:0] CFG_T1_LOW      = 3'd4;
    localparam logic [IDX_W-1:0] CFG_RESET_TICKS = 3'd5;

    // Register values after reset.
    localparam logic [PINS_W-1:0] PIN_MASK_RST    = 32'd0;
    localparam logic [DUR_W-1:0]  T0_HIGH_RST     = 16'd20;
    localparam logic [DUR_W-1:0]  T0_LOW_RST      = 16'd57;
    localparam logic [DUR_W-1:0]  T1_HIGH_RST     = 16'd60;
    localparam logic [DUR_W-1:0]  T1_LOW_RST      = 16'd12;
    localparam logic [TICK_W-1:0] RESET_TICKS_RST = 24'd2400000;

    typedef struct packed {
        logic [1:0]        func;
        logic [WORD_W-1:0] data_word;
    } t_in;

    typedef struct packed {
        logic [PINS_W-1:0] pins;
        logic              ready_res;
        logic              dropped;
        logic              frame_done;
    } t_out;

    typedef struct packed {
        logic [PINS_W-1:0] pin_mask;
        logic [DUR_W-1:0]  t0_high;
        logic [DUR_W-1:0]  t0_low;
        logic [DUR_W-1:0]  t1_high;
        logic [DUR_W-1:0]  t1_low;
        logic [TICK_W-1:0] reset_ticks;
    } t_cfg;

endpackage

### src/albs_cfg.sv
// Configuration register bank of the addressable LED bit serializer.
// Depends on albs_pkg for the register indexes, reset values and the t_cfg struct.
module albs_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [albs_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                  i_cfg_data,
    output albs_pkg::t_cfg               o_cfg
);
    import albs_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pin_mask    <= PIN_MASK_RST;
            r_cfg.t0_high     <= T0_HIGH_RST;
            r_cfg.t0_low      <= T0_LOW_RST;
            r_cfg.t1_high     <= T1_HIGH_RST;
            r_cfg.t1_low      <= T1_LOW_RST;
            r_cfg.reset_ticks <= RESET_TICKS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PIN_MASK:    r_cfg.pin_mask    <= i_cfg_data[PINS_W-1:0];
                CFG_T0_HIGH:     r_cfg.t0_high     <= i_cfg_data[DUR_W-1:0];
                CFG_T0_LOW:      r_cfg.t0_low      <= i_cfg_data[DUR_W-1:0];
                CFG_T1_HIGH:     r_cfg.t1_high     <= i_cfg_data[DUR_W-1:0];
                CFG_T1_LOW:      r_cfg.t1_low      <= i_cfg_data[DUR_W-1:0];
                CFG_RESET_TICKS: r_cfg.reset_ticks <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

### src/albs_core.sv
// Waveform sequencer of the addressable LED bit serializer: pulse state and result register.
// Depends on albs_pkg for the item structs, function codes and the t_cfg struct.
module albs_core #(
    parameter int PIN_COUNT = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  albs_pkg::t_cfg   i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  albs_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output albs_pkg::t_out   o_out_data
);
    import albs_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2,
        PH_LATCH = 2'd3
    } t_phase;

    t_phase              r_phase, n_phase, ph_a;
    logic [TICK_W-1:0]   r_tick_left, n_tick_left, tl_a, tl_dec;
    logic [WORD_W-1:0]   r_bit_shift, n_bit_shift;
    logic [POS_W-1:0]    r_bit_position, n_bit_position, pos_nxt;
    logic                r_out_valid;
    t_out                r_out, n_out;
    logic [PINS_W-1:0]   pin_limit;
    logic                accept;
    logic                idle_now;
    logic                offer;

    // Bytes go out in order 0..3, each byte MSB first.
    function automatic logic bit_at(input logic [WORD_W-1:0] shift,
                                    input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] idx;
        idx = {pos[4:3], ~pos[2:0]};
        return shift[idx];
    endfunction

    function automatic logic [TICK_W-1:0] dur(input logic [DUR_W-1:0] d);
        return (d == '0) ? TICK_W'(1) : TICK_W'(d);
    endfunction

    always_comb begin
        for (int i = 0; i < PINS_W; i++) begin
            pin_limit[i] = (i < PIN_COUNT);
        end
    end

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        idle_now    = (r_phase == PH_IDLE);
        offer       = (i_in_data.func == FUNC_WORD) || (i_in_data.func == FUNC_END);
        ph_a        = r_phase;
        tl_a        = r_tick_left;
        n_bit_shift = r_bit_shift;
        n_bit_position = r_bit_position;
        n_out.ready_res  = idle_now;
        n_out.dropped    = offer && !idle_now;
        n_out.frame_done = 1'b0;

        if (offer && idle_now) begin
            if (i_in_data.func == FUNC_WORD) begin
                n_bit_shift    = i_in_data.data_word;
                n_bit_position = '0;
                ph_a           = PH_HIGH;
                tl_a = bit_at(i_in_data.data_word, '0) ? dur(i_cfg.t1_high)
                                                        : dur(i_cfg.t0_high);
            end else begin
                ph_a = PH_LATCH;
                tl_a = (i_cfg.reset_ticks == '0) ? TICK_W'(1) : i_cfg.reset_ticks;
            end
        end

        n_out.pins = (ph_a == PH_HIGH) ? (i_cfg.pin_mask & pin_limit) : '0;

        n_phase     = ph_a;
        n_tick_left = tl_a;
        tl_dec      = tl_a - TICK_W'(1);
        pos_nxt     = n_bit_position + POS_W'(1);
        if (ph_a != PH_IDLE) begin
            n_tick_left = tl_dec;
            if (tl_dec == '0) begin
                unique case (ph_a)
                    PH_HIGH: begin
                        n_phase     = PH_LOW;
                        n_tick_left = bit_at(n_bit_shift, n_bit_position)
                                      ? dur(i_cfg.t1_low) : dur(i_cfg.t0_low);
                    end
                    PH_LOW: begin
                        if (n_bit_position == '1) begin
                            n_phase        = PH_IDLE;
                            n_bit_position = '0;
                        end else begin
                            n_bit_position = pos_nxt;
                            n_phase        = PH_HIGH;
                            n_tick_left    = bit_at(n_bit_shift, pos_nxt)
                                             ? dur(i_cfg.t1_high) : dur(i_cfg.t0_high);
                        end
                    end
                    PH_LATCH: begin
                        n_phase          = PH_IDLE;
                        n_out.frame_done = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_tick_left    <= '0;
            r_bit_shift    <= '0;
            r_bit_position <= '0;
            r_out_valid    <= 1'b0;
            r_out          <= '0;
        end else begin
            if (accept) begin
                r_phase        <= n_phase;
                r_tick_left    <= n_tick_left;
                r_bit_shift    <= n_bit_shift;
                r_bit_position <= n_bit_position;
                r_out_valid    <= 1'b1;
                r_out          <= n_out;
            end else if (i_out_ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    // An idle sequencer always sits at the start of a word with no count left.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_tick_left == '0 && r_bit_position == '0))
        else $error("idle phase with leftover count or position");

    // Any active phase still has at least its current tick to run.
    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_tick_left != '0))
        else $error("active phase with zero ticks left");

    // The latch period ends with the pins low.
    a_done_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_done) |-> (r_out.pins == '0))
        else $error("frame done reported with pins driven");

    // A word or frame end offered while the block is busy is flagged as dropped.
    a_drop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && offer && r_phase != PH_IDLE) |=> (r_out.dropped && !r_out.ready_res))
        else $error("busy offer not flagged as dropped");
`endif

endmodule

### src/addressable_led_bit_serializer_top.sv
// Top level of the addressable LED bit serializer.
// Depends on albs_pkg, albs_cfg and albs_core.
//
// Each input transfer is one tick of the LED waveform: func selects an idle
// tick, a tick that offers a 32-bit word, or a tick that ends the frame. A word
// is sent as 32 pulses, byte 0 first and each byte MSB first; every pulse is a
// high interval on the masked pins followed by a low interval, with lengths
// taken from the configuration registers. Frame end holds the pins low for
// reset_ticks and flags frame_done on the last tick.
// Every input transfer yields exactly one registered result transfer,
// from a single result register; a new tick is taken every cycle, so the
// waveform runs at one tick per clock while the receiver keeps ready high.
// When the receiver stalls, the result register holds and input ready drops
// until that result is taken; the waveform only advances on accepted ticks.
// A word or frame end offered while busy is flagged dropped.
// Reset loads the register defaults and leaves the sequencer idle with no
// result pending. Configuration writes are taken every cycle.
module addressable_led_bit_serializer_top #(
    parameter int PIN_COUNT = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [albs_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  albs_pkg::t_in                i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output albs_pkg::t_out               o_out_data
);
    import albs_pkg::*;

    t_cfg cfg;

    albs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    albs_core #(
        .PIN_COUNT (PIN_COUNT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
